### sv/session_cache_round_robin_unit_macros.svh
// -----------------------------------------------------------------------------
// session_cache_round_robin_unit_macros.svh
// Assertion macros for the session cache. They are empty in synthesis builds.
// -----------------------------------------------------------------------------
`ifndef SESSION_CACHE_ROUND_ROBIN_UNIT_MACROS_SVH
`define SESSION_CACHE_ROUND_ROBIN_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SCRR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("session cache assertion failed");
// next-cycle implication
`define SCRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("session cache assertion failed");
`else
`define SCRR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SCRR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/scrr_pkg.sv
// -----------------------------------------------------------------------------
// scrr_pkg
// Sizes, command and status codes, and the byte mask helper of the cache.
// -----------------------------------------------------------------------------
package scrr_pkg;

  // cache geometry
  localparam int ENTRIES    = 64;
  localparam int KEY_BYTES  = 32;
  localparam int DATA_BYTES = 512;
  localparam int KEY_WORDS  = (KEY_BYTES + 7) / 8;
  localparam int DATA_WORDS = (DATA_BYTES + 7) / 8;

  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int KWORD_W = $clog2(KEY_WORDS);
  localparam int DWORD_W = $clog2(DATA_WORDS);
  localparam int KADDR_W = SLOT_W + KWORD_W;
  localparam int DADDR_W = SLOT_W + DWORD_W;

  // field widths
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 6;
  localparam int WORD_W   = 64;
  localparam int KLEN_W   = 6;
  localparam int DLEN_W   = 10;
  localparam int STATUS_W = 2;
  localparam int LENS_W   = KLEN_W + DLEN_W;

  // input beat layout
  localparam int IN_CMD_LSB  = 0;
  localparam int IN_IDX_LSB  = IN_CMD_LSB + CMD_W;
  localparam int IN_VAL_LSB  = IN_IDX_LSB + IDX_W;
  localparam int IN_KLEN_LSB = IN_VAL_LSB + WORD_W;
  localparam int IN_DLEN_LSB = IN_KLEN_LSB + KLEN_W;
  localparam int IN_BITS     = IN_DLEN_LSB + DLEN_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // output beat layout
  localparam int OUT_BITS    = STATUS_W + WORD_W + DLEN_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // command codes
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_LOAD_KEY  = 3'd0;
  localparam cmd_t CMD_LOAD_DATA = 3'd1;
  localparam cmd_t CMD_STORE     = 3'd2;
  localparam cmd_t CMD_FETCH     = 3'd3;
  localparam cmd_t CMD_DELETE    = 3'd4;

  // status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_MISS     = 2'd1;
  localparam status_t STATUS_TOO_LONG = 2'd2;

  // bytes of word w that lie below byte length len
  function automatic logic [WORD_W-1:0] byte_mask(input logic [DLEN_W-1:0] len,
                                                  input logic [DWORD_W-1:0] w);
    logic [WORD_W-1:0] m;
    logic [DLEN_W:0]   base;
    logic [DLEN_W:0]   len_x;
    base  = (DLEN_W+1)'({w, 3'b000});
    len_x = {1'b0, len};
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = {8{len_x > (base + (DLEN_W+1)'(b))}};
    end
    return m;
  endfunction

endpackage

### sv/scrr_ram.sv
// -----------------------------------------------------------------------------
// scrr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
module scrr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/session_cache_round_robin_unit.sv
// -----------------------------------------------------------------------------
// session_cache_round_robin_unit
// Load, store, fetch and delete take one beat each; loads and unknown commands
// answer through ST_DONE and the output register, a store after ST_COPY.
// Fetch and delete scan slot keys one word a cycle through the key RAM read
// port; a fetch hit with data then streams each word through the data RAM read
// port (ST_FETCH_RD, ST_FETCH_WR). One command is in work at a time.
// Reset empties all slots and zeroes the write pointer at once (no sweep).
// -----------------------------------------------------------------------------
`include "session_cache_round_robin_unit_macros.svh"

module session_cache_round_robin_unit
  import scrr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // command, word_index, word_value, key_length, data_length (low bit up)
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status, data_word, found_length (low bit up)
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DONE     = 6'b000010,
    ST_COPY     = 6'b000100,
    ST_SCAN     = 6'b001000,
    ST_FETCH_RD = 6'b010000,
    ST_FETCH_WR = 6'b100000
  } state_t;

  state_t state;

  // input fields
  cmd_t              in_cmd;
  logic [IDX_W-1:0]  in_idx;
  logic [WORD_W-1:0] in_val;
  logic [KLEN_W-1:0] in_klen;
  logic [DLEN_W-1:0] in_dlen;
  logic              accept;

  assign in_cmd  = s_tdata[IN_IDX_LSB-1:IN_CMD_LSB];
  assign in_idx  = s_tdata[IN_VAL_LSB-1:IN_IDX_LSB];
  assign in_val  = s_tdata[IN_KLEN_LSB-1:IN_VAL_LSB];
  assign in_klen = s_tdata[IN_DLEN_LSB-1:IN_KLEN_LSB];
  assign in_dlen = s_tdata[IN_BITS-1:IN_DLEN_LSB];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // request and control registers
  cmd_t               req_cmd;
  logic [KLEN_W-1:0]  req_klen;
  logic [DLEN_W-1:0]  req_dlen;
  status_t            done_status;
  logic [SLOT_W-1:0]  wr_ptr;
  logic [ENTRIES-1:0] slot_valid;
  logic [WORD_W-1:0]  staged_key [KEY_WORDS];
  logic [DWORD_W:0]   copy_cnt;
  logic [KADDR_W-1:0] scan_cnt;
  logic [KADDR_W-1:0] s1_addr;
  logic               s1_valid;
  logic               match_acc;
  logic [SLOT_W-1:0]  found_slot;
  logic [DLEN_W-1:0]  found_len;
  logic [DWORD_W-1:0] word_cnt;

  // output register
  status_t            out_status;
  logic [WORD_W-1:0]  out_word;
  logic [DLEN_W-1:0]  out_len;
  logic               out_free;
  logic               out_load;

  // RAM ports
  logic               sd_wr_en, sd_rd_en;
  logic [DWORD_W-1:0] sd_wr_addr, sd_rd_addr;
  logic [WORD_W-1:0]  sd_rd_data;
  logic               kw_wr_en, kw_rd_en;
  logic [KADDR_W-1:0] kw_wr_addr;
  logic [WORD_W-1:0]  kw_wr_data, kw_rd_data;
  logic               dw_wr_en, dw_rd_en;
  logic [DADDR_W-1:0] dw_wr_addr, dw_rd_addr;
  logic [WORD_W-1:0]  dw_rd_data;
  logic               ln_wr_en, ln_rd_en;
  logic [LENS_W-1:0]  ln_wr_data, ln_rd_data;

  // staged key register file, one read index
  logic [KWORD_W-1:0] sk_rd_idx;
  logic [WORD_W-1:0]  sk_rd_word;

  // scan compare
  logic [SLOT_W-1:0]  s1_slot;
  logic [KWORD_W-1:0] s1_word;
  logic [WORD_W-1:0]  key_mask;
  logic               word_eq;
  logic               head_ok;
  logic               slot_match;
  logic               scan_last_word;
  logic               scan_hit;
  logic               scan_miss;

  // fetch word count
  logic [DLEN_W:0]    len_round;
  logic [DLEN_W-3:0]  fetch_nw;
  logic [DLEN_W-3:0]  word_cnt_ext;
  logic               fetch_last;
  logic [DWORD_W-1:0] copy_prev;
  logic [DWORD_W:0]   copy_dec;

  // staged data RAM: loads write, store copy reads
  always_comb begin
    sd_wr_en   = accept && (in_cmd == CMD_LOAD_DATA) &&
                 ({1'b0, in_idx} < (IDX_W+1)'(DATA_WORDS));
    sd_wr_addr = in_idx[DWORD_W-1:0];
    sd_rd_en   = (state == ST_COPY) && (copy_cnt < (DWORD_W+1)'(DATA_WORDS));
    sd_rd_addr = copy_cnt[DWORD_W-1:0];
  end

  scrr_ram #(.WIDTH(WORD_W), .DEPTH(DATA_WORDS)) u_staged_data (
    .clk     (clk),
    .wr_en   (sd_wr_en),
    .wr_addr (sd_wr_addr),
    .wr_data (in_val),
    .rd_en   (sd_rd_en),
    .rd_addr (sd_rd_addr),
    .rd_data (sd_rd_data)
  );

  // staged key read index is shared by copy and scan
  assign sk_rd_idx  = (state == ST_COPY) ? copy_cnt[KWORD_W-1:0] : s1_word;
  assign sk_rd_word = staged_key[sk_rd_idx];

  // copy pipeline: data written in the cycle after its staged read
  assign copy_dec  = copy_cnt - 1'b1;
  assign copy_prev = copy_dec[DWORD_W-1:0];

  // slot key RAM: written by store, read by scan
  always_comb begin
    kw_wr_en   = (state == ST_COPY) && (copy_cnt < (DWORD_W+1)'(KEY_WORDS));
    kw_wr_addr = {wr_ptr, copy_cnt[KWORD_W-1:0]};
    kw_wr_data = sk_rd_word;
    kw_rd_en   = (state == ST_SCAN);
  end

  scrr_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES * KEY_WORDS)) u_slot_keys (
    .clk     (clk),
    .wr_en   (kw_wr_en),
    .wr_addr (kw_wr_addr),
    .wr_data (kw_wr_data),
    .rd_en   (kw_rd_en),
    .rd_addr (scan_cnt),
    .rd_data (kw_rd_data)
  );

  // slot data RAM: written by store, read by fetch
  always_comb begin
    dw_wr_en   = (state == ST_COPY) && (copy_cnt != '0);
    dw_wr_addr = {wr_ptr, copy_prev};
    dw_rd_en   = (state == ST_FETCH_RD);
    dw_rd_addr = {found_slot, word_cnt};
  end

  scrr_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES * DATA_WORDS)) u_slot_data (
    .clk     (clk),
    .wr_en   (dw_wr_en),
    .wr_addr (dw_wr_addr),
    .wr_data (sd_rd_data),
    .rd_en   (dw_rd_en),
    .rd_addr (dw_rd_addr),
    .rd_data (dw_rd_data)
  );

  // slot length RAM {key_len, data_len}; the scan masks an invalid slot by slot_valid
  always_comb begin
    ln_wr_en   = (state == ST_COPY) && (copy_cnt == (DWORD_W+1)'(DATA_WORDS));
    ln_wr_data = {req_klen, req_dlen};
    ln_rd_en   = (state == ST_SCAN);
  end

  scrr_ram #(.WIDTH(LENS_W), .DEPTH(ENTRIES)) u_slot_lens (
    .clk     (clk),
    .wr_en   (ln_wr_en),
    .wr_addr (wr_ptr),
    .wr_data (ln_wr_data),
    .rd_en   (ln_rd_en),
    .rd_addr (scan_cnt[KADDR_W-1:KWORD_W]),
    .rd_data (ln_rd_data)
  );

  // scan compare on the word read last cycle
  always_comb begin
    s1_slot        = s1_addr[KADDR_W-1:KWORD_W];
    s1_word        = s1_addr[KWORD_W-1:0];
    key_mask       = byte_mask(DLEN_W'(req_klen), DWORD_W'(s1_word));
    word_eq        = ((kw_rd_data ^ sk_rd_word) & key_mask) == '0;
    head_ok        = slot_valid[s1_slot] && (ln_rd_data[LENS_W-1:DLEN_W] == req_klen);
    slot_match     = ((s1_word == '0) ? head_ok : match_acc) && word_eq;
    scan_last_word = (s1_word == KWORD_W'(KEY_WORDS - 1));
    scan_hit       = s1_valid && scan_last_word && slot_match;
    scan_miss      = s1_valid && scan_last_word && !slot_match &&
                     (s1_slot == SLOT_W'(ENTRIES - 1));
  end

  // words to send on a hit
  assign len_round    = {1'b0, found_len} + (DLEN_W+1)'(7);
  assign fetch_nw     = len_round[DLEN_W:3];
  assign word_cnt_ext = (DLEN_W-2)'(word_cnt);
  assign fetch_last   = (word_cnt_ext + 1'b1) == fetch_nw;

  // output register handshake
  assign out_free = !m_tvalid || m_tready;
  assign out_load = ((state == ST_DONE) || (state == ST_FETCH_WR)) && out_free;

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_FETCH_WR) begin
        out_status <= STATUS_OK;
        out_word   <= dw_rd_data & byte_mask(found_len, word_cnt);
        out_len    <= found_len;
        m_tlast    <= fetch_last;
      end else begin
        out_status <= done_status;
        out_word   <= '0;
        out_len    <= '0;
        m_tlast    <= 1'b1;
      end
    end
  end

  assign m_tdata = {(OUT_TDATA_W - OUT_BITS)'(0), out_len, out_word, out_status};

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      wr_ptr     <= '0;
      s1_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req_cmd  <= in_cmd;
            req_klen <= in_klen;
            req_dlen <= in_dlen;
            case (in_cmd)
              CMD_LOAD_KEY: begin
                if (in_idx < IDX_W'(KEY_WORDS)) begin
                  staged_key[in_idx[KWORD_W-1:0]] <= in_val;
                end
                done_status <= STATUS_OK;
                state       <= ST_DONE;
              end
              CMD_STORE: begin
                if (({1'b0, in_klen} > (KLEN_W+1)'(KEY_BYTES)) ||
                    ({1'b0, in_dlen} > (DLEN_W+1)'(DATA_BYTES))) begin
                  done_status <= STATUS_TOO_LONG;
                  state       <= ST_DONE;
                end else begin
                  copy_cnt <= '0;
                  state    <= ST_COPY;
                end
              end
              CMD_FETCH, CMD_DELETE: begin
                if ((in_klen == '0) || ({1'b0, in_klen} > (KLEN_W+1)'(KEY_BYTES))) begin
                  done_status <= STATUS_MISS;
                  state       <= ST_DONE;
                end else begin
                  scan_cnt <= '0;
                  s1_valid <= 1'b0;
                  state    <= ST_SCAN;
                end
              end
              default: begin
                done_status <= STATUS_OK;
                state       <= ST_DONE;
              end
            endcase
          end
        end

        // copy staged key and data into the slot at the pointer
        ST_COPY: begin
          copy_cnt <= copy_cnt + 1'b1;
          if (copy_cnt == (DWORD_W+1)'(DATA_WORDS)) begin
            slot_valid[wr_ptr] <= 1'b1;
            wr_ptr      <= (wr_ptr == SLOT_W'(ENTRIES - 1)) ? '0 : wr_ptr + 1'b1;
            done_status <= STATUS_OK;
            state       <= ST_DONE;
          end
        end

        // one key word a cycle, lowest slot first
        ST_SCAN: begin
          scan_cnt  <= scan_cnt + 1'b1;
          s1_addr   <= scan_cnt;
          s1_valid  <= 1'b1;
          match_acc <= slot_match;
          if (scan_hit) begin
            s1_valid <= 1'b0;
            if (req_cmd == CMD_DELETE) begin
              slot_valid[s1_slot] <= 1'b0;
              done_status <= STATUS_OK;
              state       <= ST_DONE;
            end else begin
              found_slot <= s1_slot;
              found_len  <= ln_rd_data[DLEN_W-1:0];
              word_cnt   <= '0;
              if (ln_rd_data[DLEN_W-1:0] == '0) begin
                done_status <= STATUS_OK;
                state       <= ST_DONE;
              end else begin
                state <= ST_FETCH_RD;
              end
            end
          end else if (scan_miss) begin
            s1_valid    <= 1'b0;
            done_status <= STATUS_MISS;
            state       <= ST_DONE;
          end
        end

        ST_FETCH_RD: begin
          state <= ST_FETCH_WR;
        end

        // hand one data word to the output register
        ST_FETCH_WR: begin
          if (out_free) begin
            if (fetch_last) begin
              state <= ST_IDLE;
            end else begin
              word_cnt <= word_cnt + 1'b1;
              state    <= ST_FETCH_RD;
            end
          end
        end

        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `SCRR_ASSERT_IMPL(a_fetch_slot_valid, clk, rst, state == ST_FETCH_RD, slot_valid[found_slot])
  `SCRR_ASSERT_IMPL(a_fetch_word_range, clk, rst, state == ST_FETCH_WR, word_cnt_ext < fetch_nw)
  `SCRR_ASSERT_NEXT(a_scan_ends, clk, rst, state == ST_SCAN && (scan_hit || scan_miss), state != ST_SCAN)
  `SCRR_ASSERT_IMPL(a_scan_key_nonzero, clk, rst, state == ST_SCAN && s1_valid, req_klen != '0)

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Drives load, store, fetch, delete and unused-code beats into the session cache through
// the input stream. A mirror of the cache predicts every response beat, and
// each accepted output beat is checked field by field against the oldest
// prediction. Both stream sides idle at random.
// -----------------------------------------------------------------------------
module testbench;
  import scrr_pkg::*;

  // codes the block answers without acting on them
  localparam cmd_t CMD_UNUSED_FIRST = 3'd5;
  localparam cmd_t CMD_UNUSED_LAST  = 3'd7;

  // output beat layout
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_WORD_LSB   = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_LEN_LSB    = OUT_WORD_LSB + WORD_W;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = ENTRIES * KEY_WORDS + 2 * DATA_WORDS + 16;
  localparam int POOL_KEYS     = 6;
  localparam int RANDOM_ITEMS  = 130;

  typedef struct {
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] value;
    logic [KLEN_W-1:0] klen;
    logic [DLEN_W-1:0] dlen;
  } command_t;

  typedef struct {
    status_t           status;
    logic [WORD_W-1:0] data_word;
    logic [DLEN_W-1:0] found_length;
    logic              last;
  } response_t;

  // Mirror of the cache contents and the queue of response beats it predicts
  class cache_mirror;
    logic [WORD_W-1:0] slot_key [ENTRIES][KEY_WORDS];
    logic [WORD_W-1:0] slot_data [ENTRIES][DATA_WORDS];
    int unsigned       slot_klen [ENTRIES];
    int unsigned       slot_dlen [ENTRIES];
    logic [WORD_W-1:0] staged_key [KEY_WORDS];
    logic [WORD_W-1:0] staged_data [DATA_WORDS];
    int unsigned       write_ptr;
    response_t         pending_responses[$];
    int                errors;

    // bytes of word w that lie below a byte length
    static function logic [WORD_W-1:0] live_bytes(int unsigned len, int unsigned w);
      int unsigned rest;
      if (len <= 8 * w) return '0;
      rest = len - 8 * w;
      if (rest >= 8) return '1;
      return (64'd1 << (8 * rest)) - 64'd1;
    endfunction

    function void push_response(status_t st, logic [WORD_W-1:0] word,
                                int unsigned len, bit last);
      response_t r;
      r.status       = st;
      r.data_word    = word;
      r.found_length = DLEN_W'(len);
      r.last         = last;
      pending_responses.push_back(r);
    endfunction

    // lowest slot whose length and live key bytes match the staged key
    function int lookup_slot(int unsigned klen);
      if (klen == 0 || klen > KEY_BYTES) return -1;
      for (int s = 0; s < ENTRIES; s++) begin
        bit same;
        same = (slot_klen[s] == klen);
        for (int w = 0; w < KEY_WORDS; w++)
          if (same && ((slot_key[s][w] ^ staged_key[w]) & live_bytes(klen, w)) != 0)
            same = 0;
        if (same) return s;
      end
      return -1;
    endfunction

    function void absorb_command(command_t c);
      int          hit;
      int unsigned len;
      int unsigned nwords;
      case (c.cmd)
        CMD_LOAD_KEY: begin
          if (c.idx < KEY_WORDS) staged_key[c.idx] = c.value;
          push_response(STATUS_OK, '0, 0, 1);
        end
        CMD_LOAD_DATA: begin
          if (c.idx < DATA_WORDS) staged_data[c.idx] = c.value;
          push_response(STATUS_OK, '0, 0, 1);
        end
        CMD_STORE: begin
          if (c.klen > KEY_BYTES || c.dlen > DATA_BYTES) begin
            push_response(STATUS_TOO_LONG, '0, 0, 1);
          end else begin
            slot_key[write_ptr]  = staged_key;
            slot_data[write_ptr] = staged_data;
            slot_klen[write_ptr] = c.klen;
            slot_dlen[write_ptr] = c.dlen;
            write_ptr = (write_ptr + 1) % ENTRIES;
            push_response(STATUS_OK, '0, 0, 1);
          end
        end
        CMD_FETCH: begin
          hit = lookup_slot(c.klen);
          if (hit < 0) begin
            push_response(STATUS_MISS, '0, 0, 1);
          end else if (slot_dlen[hit] == 0) begin
            push_response(STATUS_OK, '0, 0, 1);
          end else begin
            len    = slot_dlen[hit];
            nwords = (len + 7) / 8;
            for (int unsigned w = 0; w < nwords; w++)
              push_response(STATUS_OK, slot_data[hit][w] & live_bytes(len, w), len,
                            w + 1 == nwords);
          end
        end
        CMD_DELETE: begin
          hit = lookup_slot(c.klen);
          if (hit < 0) begin
            push_response(STATUS_MISS, '0, 0, 1);
          end else begin
            slot_klen[hit] = 0;
            slot_dlen[hit] = 0;
            push_response(STATUS_OK, '0, 0, 1);
          end
        end
        default: push_response(STATUS_OK, '0, 0, 1);
      endcase
    endfunction

    function void check_response(response_t got);
      response_t want;
      if (pending_responses.size() == 0) begin
        errors++;
        $error("output beat with no response pending");
        return;
      end
      want = pending_responses.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, got.status);
      end
      if (got.data_word !== want.data_word) begin
        errors++;
        $error("data_word: expected %h, got %h", want.data_word, got.data_word);
      end
      if (got.found_length !== want.found_length) begin
        errors++;
        $error("found_length: expected %0d, got %0d", want.found_length,
               got.found_length);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last: expected %0d, got %0d", want.last, got.last);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  cache_mirror mirror = new;
  bit          no_gaps = 0;
  int          quiet_cycles = 0;
  int          commands_sent = 0;

  // key pool for store / lookup sequences
  int unsigned       pool_len [POOL_KEYS];
  logic [WORD_W-1:0] pool_key [POOL_KEYS][KEY_WORDS];

  session_cache_round_robin_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic command_t make_command(cmd_t cmd, int unsigned idx,
                                            logic [WORD_W-1:0] value,
                                            int unsigned klen, int unsigned dlen);
    command_t c;
    c.cmd   = cmd;
    c.idx   = IDX_W'(idx);
    c.value = value;
    c.klen  = KLEN_W'(klen);
    c.dlen  = DLEN_W'(dlen);
    return c;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_command(command_t c);
    logic [IN_TDATA_W-1:0] beat;
    beat = '0;
    beat[IN_CMD_LSB  +: CMD_W]  = c.cmd;
    beat[IN_IDX_LSB  +: IDX_W]  = c.idx;
    beat[IN_VAL_LSB  +: WORD_W] = c.value;
    beat[IN_KLEN_LSB +: KLEN_W] = c.klen;
    beat[IN_DLEN_LSB +: DLEN_W] = c.dlen;
    return beat;
  endfunction

  // mostly short data so that most hits stream only a few words
  function automatic int unsigned pick_data_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return $urandom_range(64);
    if (roll < 80) return $urandom_range(511, 65);
    if (roll < 88) return DATA_BYTES;
    return $urandom_range(8);
  endfunction

  // One input beat; valid stays high into the next call unless it idles
  task automatic send_command(command_t c);
    while (!no_gaps && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_command(c);
    do @(posedge clk); while (!s_tready);
    mirror.absorb_command(c);
    if (!(c.cmd == CMD_LOAD_KEY && c.idx >= KEY_WORDS)) commands_sent++;
  endtask

  // hold off the sender until every predicted beat has come back
  task automatic drain_responses();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (mirror.pending_responses.size() != 0);
  endtask

  // stage a pool key; bytes past its length get fresh garbage
  task automatic stage_pool_key(int p);
    logic [WORD_W-1:0] mask;
    for (int w = 0; w < (pool_len[p] + 7) / 8; w++) begin
      mask = cache_mirror::live_bytes(pool_len[p], w);
      send_command(make_command(CMD_LOAD_KEY, w,
                                (pool_key[p][w] & mask) | (rand_word() & ~mask), 0, 0));
    end
  endtask

  // Output side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mirror.check_response('{status:       m_tdata[OUT_STATUS_LSB +: STATUS_W],
                              data_word:    m_tdata[OUT_WORD_LSB +: WORD_W],
                              found_length: m_tdata[OUT_LEN_LSB +: DLEN_W],
                              last:         m_tlast});
    end
    m_tready <= no_gaps || ($urandom_range(99) >= 20);
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned       roll;
    int unsigned       p;
    int unsigned       klen;
    int                seq;
    logic [WORD_W-1:0] key_word;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill every staging word so no store copies an unwritten one
    for (int w = 0; w < KEY_WORDS; w++)
      send_command(make_command(CMD_LOAD_KEY, w, rand_word(), 0, 0));
    for (int w = 0; w < DATA_WORDS; w++)
      send_command(make_command(CMD_LOAD_DATA, w, rand_word(), 0, 0));

    // directed: extremes, too-long stores, zero-length keys, empty hit
    // both sides run without idling through this stretch
    no_gaps = 1;
    send_command(make_command(CMD_LOAD_KEY, 0, '1, 0, 0));
    send_command(make_command(CMD_LOAD_KEY, 63, '1, 0, 0));
    send_command(make_command(CMD_LOAD_DATA, 63, '1, 0, 0));
    send_command(make_command(CMD_LOAD_DATA, 0, '0, 0, 0));
    send_command(make_command(CMD_STORE, 0, '0, KEY_BYTES, DATA_BYTES));
    send_command(make_command(CMD_FETCH, 0, '0, KEY_BYTES, 0));
    send_command(make_command(CMD_STORE, 0, '0, KEY_BYTES + 1, 0));
    send_command(make_command(CMD_STORE, 0, '0, 1, DATA_BYTES + 1));
    send_command(make_command(CMD_STORE, 0, '1, 63, 1023));
    send_command(make_command(CMD_STORE, 0, '0, 0, 8));
    send_command(make_command(CMD_FETCH, 0, '0, 0, 0));
    send_command(make_command(CMD_DELETE, 0, '0, 0, 0));
    send_command(make_command(CMD_STORE, 0, '0, 1, 0));
    send_command(make_command(CMD_FETCH, 0, '0, 1, 0));
    send_command(make_command(CMD_LOAD_KEY, 0, '0, 0, 0));
    send_command(make_command(CMD_FETCH, 0, '0, 1, 0));
    send_command(make_command(CMD_STORE, 0, '0, 8, 1));
    send_command(make_command(CMD_FETCH, 0, '0, 8, 0));
    send_command(make_command(CMD_FETCH, 0, '0, 63, 0));
    for (int k = CMD_UNUSED_FIRST; k <= CMD_UNUSED_LAST; k++)
      send_command(make_command(cmd_t'(k), $urandom_range(63), rand_word(),
                                $urandom_range(63), $urandom_range(1023)));
    send_command(make_command(CMD_LOAD_KEY, 0, '1, 0, 0));
    send_command(make_command(CMD_DELETE, 0, '0, KEY_BYTES, 0));
    send_command(make_command(CMD_FETCH, 0, '0, KEY_BYTES, 0));
    no_gaps = 0;

    // key pool: shortest, longest, word boundary, just past it, random
    pool_len[0] = 1;
    pool_len[1] = KEY_BYTES;
    pool_len[2] = 8;
    pool_len[3] = 9;
    pool_len[4] = $urandom_range(KEY_BYTES, 1);
    pool_len[5] = $urandom_range(KEY_BYTES, 1);
    for (int i = 0; i < POOL_KEYS; i++)
      for (int w = 0; w < KEY_WORDS; w++)
        pool_key[i][w] = rand_word();

    // random sequences until the item budget is spent
    seq = 0;
    while (commands_sent < RANDOM_ITEMS) begin
      if (seq == 2 || $urandom_range(99) < 4) drain_responses();
      roll = $urandom_range(99);
      p    = $urandom_range(POOL_KEYS - 1);
      if (roll < 35) begin
        // put: stage key and a few data words, then store
        stage_pool_key(p);
        repeat ($urandom_range(3))
          send_command(make_command(CMD_LOAD_DATA, $urandom_range(63), rand_word(), 0, 0));
        if ($urandom_range(9) == 0)
          send_command(make_command(CMD_STORE, 0, '0, $urandom_range(63, KEY_BYTES + 1),
                                    $urandom_range(1023, DATA_BYTES + 1)));
        else
          send_command(make_command(CMD_STORE, 0, '0, pool_len[p], pick_data_length()));
      end else if (roll < 55) begin
        // lookup, now and then with a neighboring length
        stage_pool_key(p);
        klen = pool_len[p];
        if ($urandom_range(99) < 15) klen = $urandom_range(klen + 1, klen - 1);
        send_command(make_command(CMD_FETCH, 0, '0, klen, 0));
      end else if (roll < 65) begin
        // delete, then look the key up again
        stage_pool_key(p);
        send_command(make_command(CMD_DELETE, 0, '0, pool_len[p], 0));
        send_command(make_command(CMD_FETCH, 0, '0, pool_len[p], 0));
      end else if (roll < 85) begin
        // burst of stores of whatever is staged
        repeat ($urandom_range(6, 2)) begin
          klen = ($urandom_range(99) < 70) ? pool_len[$urandom_range(POOL_KEYS - 1)]
                                           : $urandom_range(KEY_BYTES);
          send_command(make_command(CMD_STORE, 0, '0, klen, pick_data_length()));
        end
      end else begin
        // noise: any command with any fields
        key_word = rand_word();
        send_command(make_command(cmd_t'($urandom_range(CMD_UNUSED_LAST)),
                                  $urandom_range(63), key_word,
                                  $urandom_range(63), $urandom_range(1023)));
      end
      seq++;
    end
    no_gaps = 0;

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/scrr_pkg.sv
sv/scrr_ram.sv
sv/session_cache_round_robin_unit.sv
dv/testbench.sv
